/* src/osm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osm_pkg: shared types, codes and sizing functions for the order statistic
// multiset.
// ----------------------------------------------------------------------------
package osm_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int VALUE_W      = 32;
    localparam int RANK_W       = 11;
    localparam int COUNT_W      = 11;
    localparam int STATUS_W     = 2;
    localparam int TREE_FANIN   = 32;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANK = 2'd2;

    // Insert broadcast seen by every cell of the chain
    typedef struct packed {
        logic                      en;
        logic signed [VALUE_W-1:0] value;
    } ins_t;

    // Number of nodes on a level of the read tree; level 0 is the leaves
    function automatic int nodes_at(input int n, input int lv);
        int x;
        x = n;
        for (int i = 0; i < lv; i++) begin
            x = (x + TREE_FANIN - 1) / TREE_FANIN;
        end
        return x;
    endfunction

    function automatic int tree_levels(input int n);
        int lv;
        lv = 1;
        while (nodes_at(n, lv) > 1) begin
            lv++;
        end
        return lv;
    endfunction

    // First flat node index of a level (levels counted from 1)
    function automatic int node_offset(input int n, input int lv);
        int sum;
        sum = 0;
        for (int m = 1; m < lv; m++) begin
            sum += nodes_at(n, m);
        end
        return sum;
    endfunction

endpackage

/* src/osm_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osm_cell: one slot of the sorted chain
// Holds one value; on an insert it keeps its value, takes the new value, or
// takes its lower neighbor's value so that the chain stays ascending.
// ----------------------------------------------------------------------------
module osm_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 11,
    parameter int IDX_W = 10
) (
    input  logic                               aclk,
    input  osm_pkg::ins_t                      ins,
    input  logic [CNT_W-1:0]                   count,
    input  logic [IDX_W-1:0]                   rd_idx,
    input  logic                               prev_gt,
    input  logic signed [osm_pkg::VALUE_W-1:0] prev_val,
    output logic                               gt,
    output logic signed [osm_pkg::VALUE_W-1:0] val,
    output logic [osm_pkg::VALUE_W-1:0]        rd_val
);

    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [osm_pkg::VALUE_W-1:0] val_reg;
    logic signed [osm_pkg::VALUE_W-1:0] val_next;
    logic                               occupied;
    logic                               at_end;

    assign occupied = MY_POS < count;
    assign at_end   = MY_POS == count;
    // New value sorts below this entry: the entry moves up one slot
    assign gt       = occupied && (ins.value < val_reg);

    always_comb begin
        val_next = val_reg;
        if (ins.en) begin
            if (prev_gt) begin
                val_next = prev_val;
            end else if (gt || at_end) begin
                val_next = ins.value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign val    = val_reg;
    assign rd_val = (MY_IDX == rd_idx) ? val_reg : '0;

endmodule

/* src/osm_read_tree.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osm_read_tree: registered OR tree over the cells' read outputs
// Only the addressed cell drives a nonzero word, so the OR yields its value.
// ----------------------------------------------------------------------------
module osm_read_tree #(
    parameter int LEAVES = 2
) (
    input  logic                                     aclk,
    input  logic [LEAVES-1:0][osm_pkg::VALUE_W-1:0]  leaf_in,
    output logic [osm_pkg::VALUE_W-1:0]              root_out
);

    localparam int F      = osm_pkg::TREE_FANIN;
    localparam int LEVELS = osm_pkg::tree_levels(LEAVES);
    localparam int TOTAL  = osm_pkg::node_offset(LEAVES, LEVELS + 1);

    logic [osm_pkg::VALUE_W-1:0] node_reg  [TOTAL];
    logic [osm_pkg::VALUE_W-1:0] node_next [TOTAL];

    for (genvar lv = 1; lv <= LEVELS; lv++) begin : g_level
        localparam int NODES     = osm_pkg::nodes_at(LEAVES, lv);
        localparam int OFF       = osm_pkg::node_offset(LEAVES, lv);
        localparam int CHILD_N   = osm_pkg::nodes_at(LEAVES, lv - 1);
        localparam int CHILD_OFF = osm_pkg::node_offset(LEAVES, lv - 1);
        for (genvar nd = 0; nd < NODES; nd++) begin : g_node
            if (lv == 1) begin : g_leaf
                always_comb begin
                    node_next[OFF+nd] = '0;
                    for (int c = 0; c < F; c++) begin
                        if (nd * F + c < CHILD_N) begin
                            node_next[OFF+nd] = node_next[OFF+nd] | leaf_in[nd*F+c];
                        end
                    end
                end
            end else begin : g_inner
                always_comb begin
                    node_next[OFF+nd] = '0;
                    for (int c = 0; c < F; c++) begin
                        if (nd * F + c < CHILD_N) begin
                            node_next[OFF+nd] = node_next[OFF+nd]
                                              | node_reg[CHILD_OFF+nd*F+c];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < TOTAL; k++) begin
            node_reg[k] <= node_next[k];
        end
    end

    assign root_out = node_reg[TOTAL-1];

endmodule

/* src/order_statistic_multiset_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_statistic_multiset_top: sorted multiset with k-th smallest queries
// Chain of CAPACITY value cells kept in ascending order, plus a registered
// read tree for rank lookups.
// ----------------------------------------------------------------------------
// An insert, a dropped insert and a query with a bad rank need no read pass:
// the chain shifts every larger entry up in the accepting cycle and the result
// goes straight to the output register, so these transactions can follow each
// other back to back while that register is free. A good query steps through
// the LEVELS levels of the 32-way registered OR tree that reads the addressed
// cell (2 levels for 1024 entries) in S_READ; the input is not ready meanwhile.
// A result that meets a full output register waits in a holding register, and
// the next transaction is accepted once it has moved out. The value store has
// no reset; the entry count clears on reset and no clearing pass is needed.
// ----------------------------------------------------------------------------
module order_statistic_multiset_top #(
    parameter int CAPACITY = osm_pkg::CAPACITY_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic signed [osm_pkg::VALUE_W-1:0]  s_item_value,
    input  logic [osm_pkg::RANK_W-1:0]          s_query_rank,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [osm_pkg::VALUE_W-1:0]  m_answer_value,
    output logic [osm_pkg::STATUS_W-1:0]        m_status,
    output logic [osm_pkg::COUNT_W-1:0]         m_stored_count
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CMP_W  = (CNT_W > osm_pkg::RANK_W) ? CNT_W : osm_pkg::RANK_W;
    localparam int LEVELS = osm_pkg::tree_levels(CAPACITY);
    localparam int LVL_W  = $clog2(LEVELS + 1);
    localparam int VW     = osm_pkg::VALUE_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_WAIT = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [LVL_W-1:0]                lvl_cnt_reg, lvl_cnt_next;
    logic [IDX_W-1:0]                rd_idx_reg, rd_idx_next;
    logic                            m_valid_reg, m_valid_next;
    logic signed [VW-1:0]            m_value_reg;
    logic [osm_pkg::STATUS_W-1:0]    m_status_reg;
    logic [osm_pkg::COUNT_W-1:0]     m_count_reg;
    logic signed [VW-1:0]            pend_value_reg;
    logic [osm_pkg::STATUS_W-1:0]    pend_status_reg;
    logic [osm_pkg::COUNT_W-1:0]     pend_count_reg;

    logic                            s_accept;
    logic                            is_ins;
    logic                            full;
    logic                            rank_ok;
    logic                            out_free;
    logic [CMP_W-1:0]                rank_ext;
    logic [CMP_W-1:0]                idx_ext;
    osm_pkg::ins_t                   ins;

    logic                            result_ready;
    logic signed [VW-1:0]            res_value;
    logic [osm_pkg::STATUS_W-1:0]    res_status;
    logic [osm_pkg::COUNT_W-1:0]     res_count;

    logic                            gt_w   [CAPACITY];
    logic signed [VW-1:0]            val_w  [CAPACITY];
    logic [CAPACITY-1:0][VW-1:0]     leaf_w;
    logic [VW-1:0]                   root_w;

    assign s_ready  = state_reg == S_IDLE;
    assign s_accept = s_valid && s_ready;
    assign is_ins   = s_command == osm_pkg::CMD_INSERT;
    assign full     = count_reg == CNT_W'(CAPACITY);
    assign out_free = !m_valid_reg || m_ready;

    assign rank_ext = CMP_W'(s_query_rank);
    assign idx_ext  = rank_ext - CMP_W'(1);
    assign rank_ok  = (rank_ext != '0) && (rank_ext <= CMP_W'(count_reg));

    assign ins.en    = s_accept && is_ins && !full;
    assign ins.value = s_item_value;

    // Sorted chain
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_first
            osm_cell #(.INDEX(i), .CNT_W(CNT_W), .IDX_W(IDX_W)) u_cell (
                .aclk     (aclk),
                .ins      (ins),
                .count    (count_reg),
                .rd_idx   (rd_idx_reg),
                .prev_gt  (1'b0),
                .prev_val ('0),
                .gt       (gt_w[i]),
                .val      (val_w[i]),
                .rd_val   (leaf_w[i])
            );
        end else begin : g_rest
            osm_cell #(.INDEX(i), .CNT_W(CNT_W), .IDX_W(IDX_W)) u_cell (
                .aclk     (aclk),
                .ins      (ins),
                .count    (count_reg),
                .rd_idx   (rd_idx_reg),
                .prev_gt  (gt_w[i-1]),
                .prev_val (val_w[i-1]),
                .gt       (gt_w[i]),
                .val      (val_w[i]),
                .rd_val   (leaf_w[i])
            );
        end
    end

    osm_read_tree #(.LEAVES(CAPACITY)) u_read_tree (
        .aclk     (aclk),
        .leaf_in  (leaf_w),
        .root_out (root_w)
    );

    assign count_next  = ins.en ? count_reg + CNT_W'(1) : count_reg;
    assign rd_idx_next = s_accept ? idx_ext[IDX_W-1:0] : rd_idx_reg;

    always_comb begin
        state_next   = state_reg;
        lvl_cnt_next = lvl_cnt_reg;
        result_ready = 1'b0;
        res_value    = '0;
        res_status   = osm_pkg::STATUS_OK;
        res_count    = osm_pkg::COUNT_W'(count_next);
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    lvl_cnt_next = '0;
                    if (!is_ins && rank_ok) begin
                        state_next = S_READ;
                    end else begin
                        result_ready = 1'b1;
                        if (is_ins) begin
                            res_status = full ? osm_pkg::STATUS_FULL : osm_pkg::STATUS_OK;
                        end else begin
                            res_status = osm_pkg::STATUS_RANK;
                        end
                        if (!out_free) begin
                            state_next = S_WAIT;
                        end
                    end
                end
            end
            S_READ: begin
                lvl_cnt_next = lvl_cnt_reg + LVL_W'(1);
                if (lvl_cnt_reg == LVL_W'(LEVELS)) begin
                    result_ready = 1'b1;
                    res_value    = root_w;
                    state_next   = out_free ? S_IDLE : S_WAIT;
                end
            end
            S_WAIT: begin
                result_ready = 1'b1;
                res_value    = pend_value_reg;
                res_status   = pend_status_reg;
                res_count    = pend_count_reg;
                state_next   = out_free ? S_IDLE : S_WAIT;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (result_ready && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            lvl_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            lvl_cnt_reg <= lvl_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_idx_next;
        // Load the output register, or hold the result until it frees up
        if (result_ready && out_free) begin
            m_value_reg  <= res_value;
            m_status_reg <= res_status;
            m_count_reg  <= res_count;
        end
        if (result_ready && !out_free) begin
            pend_value_reg  <= res_value;
            pend_status_reg <= res_status;
            pend_count_reg  <= res_count;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_answer_value = m_value_reg;
    assign m_status       = m_status_reg;
    assign m_stored_count = m_count_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && is_ins && !full) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not advance entry count");

    a_query_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !is_ins) |=> $stable(count_reg))
        else $error("query changed entry count");

    a_read_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |-> (lvl_cnt_reg <= LVL_W'(LEVELS)))
        else $error("read tree counter overran");

    a_wait_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WAIT) |-> m_valid_reg)
        else $error("held result with empty output register");

endmodule

/* sim/order_statistic_multiset_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_statistic_multiset_checker: scoreboard for the order statistic multiset
// Watches both channels, keeps a sorted copy of the multiset, predicts one
// result per accepted transaction and compares the results in order.
// ----------------------------------------------------------------------------
module order_statistic_multiset_checker #(
    parameter int CAPACITY = osm_pkg::CAPACITY_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_command,
    input  logic signed [osm_pkg::VALUE_W-1:0]  s_item_value,
    input  logic [osm_pkg::RANK_W-1:0]          s_query_rank,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [osm_pkg::VALUE_W-1:0]  m_answer_value,
    input  logic [osm_pkg::STATUS_W-1:0]        m_status,
    input  logic [osm_pkg::COUNT_W-1:0]         m_stored_count,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  stored_inserts,
    output int                                  dropped_inserts,
    output int                                  answered_queries,
    output int                                  bad_rank_queries
);
    import osm_pkg::*;

    typedef struct packed {
        logic signed [VALUE_W-1:0] answer;
        logic [STATUS_W-1:0]       status;
        logic [COUNT_W-1:0]        count;
    } outcome_t;

    outcome_t                  awaited[$];
    logic signed [VALUE_W-1:0] held_values[$];
    outcome_t                  oldest;
    int                        mismatches;
    int                        n_stored;
    int                        n_dropped;
    int                        n_answered;
    int                        n_bad_rank;

    // Apply one transaction to the sorted copy and return what the block owes
    function automatic outcome_t apply_to_multiset(input logic cmd,
                                                   input logic signed [VALUE_W-1:0] value,
                                                   input logic [RANK_W-1:0] rank);
        outcome_t outcome;
        int       pos;
        outcome.answer = '0;
        outcome.status = STATUS_OK;
        if (cmd == CMD_INSERT) begin
            if (held_values.size() >= CAPACITY) begin
                outcome.status = STATUS_FULL;
                n_dropped++;
            end else begin
                // equal copies go after the ones already held
                pos = held_values.size();
                while (pos > 0 && value < held_values[pos-1]) begin
                    pos--;
                end
                held_values.insert(pos, value);
                n_stored++;
            end
        end else if (rank == 0 || int'(rank) > held_values.size()) begin
            outcome.status = STATUS_RANK;
            n_bad_rank++;
        end else begin
            outcome.answer = held_values[rank-1];
            n_answered++;
        end
        outcome.count = COUNT_W'(held_values.size());
        return outcome;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            awaited.delete();
            held_values.delete();
            mismatches = 0;
            n_stored   = 0;
            n_dropped  = 0;
            n_answered = 0;
            n_bad_rank = 0;
        end else begin
            // retire the result first: it belongs to an earlier transaction
            if (m_valid && m_ready) begin
                if (awaited.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: unexpected result value %0d status %0d count %0d",
                                 $time, m_answer_value, m_status, m_stored_count);
                    end
                    mismatches++;
                end else begin
                    oldest = awaited.pop_front();
                    if (m_answer_value !== oldest.answer || m_status !== oldest.status ||
                        m_stored_count !== oldest.count) begin
                        if (mismatches < 10) begin
                            $display("%0t: mismatch, expected value %0d status %0d count %0d",
                                     $time, oldest.answer, oldest.status, oldest.count);
                            $display("%0t:           got value %0d status %0d count %0d",
                                     $time, m_answer_value, m_status, m_stored_count);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                awaited.push_back(apply_to_multiset(s_command, s_item_value, s_query_rank));
            end
        end
        fail_count       <= mismatches;
        pending          <= awaited.size();
        stored_inserts   <= n_stored;
        dropped_inserts  <= n_dropped;
        answered_queries <= n_answered;
        bad_rank_queries <= n_bad_rank;
    end

endmodule

/* sim/order_statistic_multiset_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_statistic_multiset_top_tb: testbench for the order statistic multiset
// Drives inserts and rank queries with random idling on both sides: a directed
// opening on extremes and duplicates, then a random mix of inserts and queries.
// ----------------------------------------------------------------------------
module order_statistic_multiset_top_tb;
    import osm_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 428;
    localparam int CYCLE_LIMIT  = 400000;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_command = CMD_INSERT;
    logic signed [VALUE_W-1:0] s_item_value = '0;
    logic [RANK_W-1:0]         s_query_rank = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [VALUE_W-1:0] m_answer_value;
    logic [STATUS_W-1:0]       m_status;
    logic [COUNT_W-1:0]        m_stored_count;

    int   fail_count;
    int   pending;
    int   stored_inserts;
    int   dropped_inserts;
    int   answered_queries;
    int   bad_rank_queries;
    int   cycle_count = 0;
    int   fill_level = 0;
    logic steady = 1'b0;

    order_statistic_multiset_top #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_item_value   (s_item_value),
        .s_query_rank   (s_query_rank),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_answer_value (m_answer_value),
        .m_status       (m_status),
        .m_stored_count (m_stored_count)
    );

    order_statistic_multiset_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_item_value     (s_item_value),
        .s_query_rank     (s_query_rank),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_answer_value   (m_answer_value),
        .m_status         (m_status),
        .m_stored_count   (m_stored_count),
        .fail_count       (fail_count),
        .pending          (pending),
        .stored_inserts   (stored_inserts),
        .dropped_inserts  (dropped_inserts),
        .answered_queries (answered_queries),
        .bad_rank_queries (bad_rank_queries)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Stall the result side at random, except through the steady stretch
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        m_ready     <= steady || ($urandom_range(99) >= 21);
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic cmd, input logic signed [VALUE_W-1:0] value,
                             input logic [RANK_W-1:0] rank);
        while (!steady && $urandom_range(99) < 21) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_item_value <= value;
        s_query_rank <= rank;
        // hold until the transaction is taken
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        if (cmd == CMD_INSERT && fill_level < CAPACITY) begin
            fill_level++;
        end
    endtask

    task automatic send_insert(input logic signed [VALUE_W-1:0] value);
        send_item(CMD_INSERT, value, RANK_W'($urandom_range(CAPACITY)));
    endtask

    task automatic send_query(input logic [RANK_W-1:0] rank);
        send_item(CMD_QUERY, $urandom(), rank);
    endtask

    // Narrow values make duplicates common; corners hit the signed extremes
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0, 1, 2: return $signed($urandom_range(16)) - 32'sd8;
            3: begin
                case ($urandom_range(3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sh0000_0000;
                    default: return 32'shffff_ffff;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    // Mostly ranks in range, with some zero and some past the fill level
    function automatic logic [RANK_W-1:0] pick_rank();
        case ($urandom_range(9))
            0: return '0;
            1: begin
                if (fill_level < CAPACITY) begin
                    return RANK_W'($urandom_range(CAPACITY, fill_level + 1));
                end else begin
                    return RANK_W'(CAPACITY);
                end
            end
            default: begin
                if (fill_level == 0) begin
                    return RANK_W'(1);
                end else begin
                    return RANK_W'($urandom_range(fill_level, 1));
                end
            end
        endcase
    endfunction

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // empty store: every rank is out of range
        send_query(RANK_W'(1));
        send_query('0);
        send_query(RANK_W'(CAPACITY));
        // extremes and duplicates
        send_insert(32'sh7fff_ffff);
        send_insert(32'sh8000_0000);
        send_insert(32'sh0000_0000);
        send_insert(32'shffff_ffff);
        send_insert(32'sh0000_0000);
        send_insert(32'sh8000_0000);
        send_insert(32'sh7fff_ffff);
        send_insert(32'sh0000_0001);
        send_query('0);
        for (int k = 1; k <= 9; k++) begin
            send_query(RANK_W'(k));
        end
        send_query(RANK_W'(CAPACITY));

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            steady <= (i >= 150 && i < 300);
            if ($urandom_range(1) == 0) begin
                send_insert(pick_value());
            end else begin
                send_query(pick_rank());
            end
        end
        steady <= 1'b0;
        s_valid <= 1'b0;

        // let the last transaction reach the scoreboard before draining
        @(posedge aclk);
        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (12) @(posedge aclk);

        $display("Covered %0d stored inserts, %0d inserts dropped on a full store,",
                 stored_inserts, dropped_inserts);
        $display("%0d answered queries and %0d bad-rank queries in %0d cycles, %0d mismatches",
                 answered_queries, bad_rank_queries, cycle_count, fail_count);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
src/osm_pkg.sv
src/osm_cell.sv
src/osm_read_tree.sv
src/order_statistic_multiset_top.sv
sim/order_statistic_multiset_checker.sv
sim/order_statistic_multiset_top_tb.sv
